/* rtl/core/ipv4rc_pkg.sv */
package ipv4rc_pkg;

    localparam int CAPTURE_BYTES_DEF = 256;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_TARGET_IP   = 3'd1;
    localparam logic [2:0] REG_LOCAL_PORT  = 3'd2;
    localparam logic [2:0] REG_REMOTE_PORT = 3'd3;
    localparam logic [2:0] REG_ECHO_ID     = 3'd4;

    // Match modes
    localparam logic [1:0] MODE_TCP  = 2'd0;
    localparam logic [1:0] MODE_ICMP = 2'd1;
    localparam logic [1:0] MODE_UDP  = 2'd2;

    localparam logic [7:0] PROTO_ICMP        = 8'd1;
    localparam logic [7:0] PROTO_TCP         = 8'd6;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_UNREACHABLE  = 8'd3;
    localparam logic [7:0] ICMP_PORT_UNREACH = 8'd3;

    typedef enum logic [2:0] {
        VERDICT_NONE        = 3'd0,
        VERDICT_TCP_REPLY   = 3'd1,
        VERDICT_ECHO_REPLY  = 3'd2,
        VERDICT_UNREACHABLE = 3'd3,
        VERDICT_PORT_UNREACH = 3'd4
    } verdict_t;

    // Everything captured from one packet, taken on its last byte
    typedef struct packed {
        logic [1:0]  mode;
        logic        len_ge_20;
        logic        len_ge_hl_20;
        logic        len_ge_hl_8;
        logic        len_ge_hl_32;
        logic        len_ge_inner;
        logic [7:0]  protocol;
        logic [31:0] sender_ip;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [7:0]  tcp_flags;
        logic [7:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] inner_dest_port;
    } snap_t;

endpackage

/* rtl/core/ipv4rc_capture.sv */
module ipv4rc_capture #(
    parameter int CAPTURE_BYTES = ipv4rc_pkg::CAPTURE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic [1:0]         mode,
    input  logic               snap_take,
    output logic               snap_valid,
    output ipv4rc_pkg::snap_t  snap
);

    localparam int CW = $clog2(CAPTURE_BYTES + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [5:0]    hl_reg, hl_next;
    logic [7:0]    proto_reg, proto_next;
    logic [31:0]   src_reg, src_next;
    logic [15:0]   first_reg, first_next;
    logic [15:0]   second_reg, second_next;
    logic [7:0]    flags_reg, flags_next;
    logic [7:0]    type_reg, type_next;
    logic [7:0]    code_reg, code_next;
    logic [5:0]    ihl_reg, ihl_next;
    logic [15:0]   idp_reg, idp_next;

    logic              snap_valid_reg;
    ipv4rc_pkg::snap_t snap_reg, snap_next;

    logic          accept;
    logic          capture_en;
    logic [5:0]    hl_eff;
    logic [CW-1:0] pos, hl_w, ihl_w, wsel, inner, hl_n_w, ihl_n_w;

    assign in_ready = !snap_valid_reg || snap_take;
    assign accept   = in_valid && in_ready;
    assign pos      = count_reg;

    assign capture_en = count_reg < CW'(CAPTURE_BYTES);
    // Header length becomes known on byte zero and applies to that same byte
    assign hl_eff = (capture_en && count_reg == '0) ? {in_byte[3:0], 2'b00} : hl_reg;
    assign hl_w   = {{(CW-6){1'b0}}, hl_eff};
    assign ihl_w  = {{(CW-6){1'b0}}, ihl_reg};
    assign wsel   = (mode == ipv4rc_pkg::MODE_TCP) ? hl_w + CW'(2) : hl_w + CW'(4);
    assign inner  = hl_w + CW'(8) + ihl_w;

    always_comb
    begin
        count_next  = count_reg;
        hl_next     = hl_reg;
        proto_next  = proto_reg;
        src_next    = src_reg;
        first_next  = first_reg;
        second_next = second_reg;
        flags_next  = flags_reg;
        type_next   = type_reg;
        code_next   = code_reg;
        ihl_next    = ihl_reg;
        idp_next    = idp_reg;
        if (capture_en)
        begin
            count_next = count_reg + CW'(1);
            hl_next    = hl_eff;
            if (pos == CW'(9))
                proto_next = in_byte;
            if (pos == CW'(12))
                src_next[31:24] = in_byte;
            if (pos == CW'(13))
                src_next[23:16] = in_byte;
            if (pos == CW'(14))
                src_next[15:8] = in_byte;
            if (pos == CW'(15))
                src_next[7:0] = in_byte;
            if (pos == hl_w)
            begin
                first_next[15:8] = in_byte;
                type_next        = in_byte;
            end
            if (pos == hl_w + CW'(1))
            begin
                first_next[7:0] = in_byte;
                code_next       = in_byte;
            end
            if (pos == wsel)
                second_next[15:8] = in_byte;
            if (pos == wsel + CW'(1))
                second_next[7:0] = in_byte;
            if (pos == hl_w + CW'(13))
                flags_next = in_byte;
            if (pos == hl_w + CW'(8))
                ihl_next = {in_byte[3:0], 2'b00};
            if (pos == inner + CW'(2))
                idp_next[15:8] = in_byte;
            if (pos == inner + CW'(3))
                idp_next[7:0] = in_byte;
        end
    end

    assign hl_n_w  = {{(CW-6){1'b0}}, hl_next};
    assign ihl_n_w = {{(CW-6){1'b0}}, ihl_next};

    always_comb
    begin
        snap_next.mode            = mode;
        snap_next.len_ge_20       = count_next >= CW'(20);
        snap_next.len_ge_hl_20    = count_next >= hl_n_w + CW'(20);
        snap_next.len_ge_hl_8     = count_next >= hl_n_w + CW'(8);
        snap_next.len_ge_hl_32    = count_next >= hl_n_w + CW'(32);
        snap_next.len_ge_inner    = count_next >= hl_n_w + CW'(12) + ihl_n_w;
        snap_next.protocol        = proto_next;
        snap_next.sender_ip       = src_next;
        snap_next.first_word      = first_next;
        snap_next.second_word     = second_next;
        snap_next.tcp_flags       = flags_next;
        snap_next.msg_type        = type_next;
        snap_next.msg_code        = code_next;
        snap_next.inner_dest_port = idp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hl_reg     <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            flags_reg  <= '0;
            type_reg   <= '0;
            code_reg   <= '0;
            ihl_reg    <= '0;
            idp_reg    <= '0;
        end
        else if (accept)
        begin
            // Drop per-packet state on the last byte, ready for the next packet
            if (in_last)
            begin
                count_reg  <= '0;
                hl_reg     <= '0;
                proto_reg  <= '0;
                src_reg    <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                flags_reg  <= '0;
                type_reg   <= '0;
                code_reg   <= '0;
                ihl_reg    <= '0;
                idp_reg    <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                hl_reg     <= hl_next;
                proto_reg  <= proto_next;
                src_reg    <= src_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                flags_reg  <= flags_next;
                type_reg   <= type_next;
                code_reg   <= code_next;
                ihl_reg    <= ihl_next;
                idp_reg    <= idp_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (accept && in_last)
            snap_valid_reg <= 1'b1;
        else if (snap_take)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_last)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

/* rtl/core/ipv4_response_classifier.sv */
// Accepts one packet byte per cycle while s_tready is high, with no gaps needed between packets.
// The edge that accepts a packet's last byte takes the packet snapshot; the
// verdict is registered from it once the m_ side is free and then presented
// on the m_ side. Throughput is one byte per cycle; the s_ side stalls only
// while both a snapshot and an unaccepted verdict are held.
// Reset clears the configuration, the per-packet capture state and both stages.
module ipv4_response_classifier #(
    parameter int CAPTURE_BYTES = ipv4rc_pkg::CAPTURE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pkt_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] verdict, [10:3] reply_flags, [18:11] icmp_code_out,
    // [50:19] sender ip, [66:51] source_port_out, [71:67] zero
    output logic [71:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [1:0]  mode_reg;
    logic [31:0] target_ip_reg;
    logic [15:0] local_port_reg;
    logic [15:0] remote_port_reg;
    logic [15:0] echo_id_reg;

    logic              snap_valid;
    logic              snap_take;
    ipv4rc_pkg::snap_t snap;

    ipv4rc_pkg::verdict_t verdict_next;
    logic [7:0]  flags_next, code_next;
    logic [15:0] sport_next;
    logic        src_match;

    logic                 out_valid_reg;
    ipv4rc_pkg::verdict_t verdict_reg;
    logic [7:0]           flags_reg, code_reg;
    logic [31:0]          sender_ip_reg;
    logic [15:0]          sport_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= '0;
            target_ip_reg   <= '0;
            local_port_reg  <= '0;
            remote_port_reg <= '0;
            echo_id_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ipv4rc_pkg::REG_MODE:        mode_reg        <= cfg_data[1:0];
                ipv4rc_pkg::REG_TARGET_IP:   target_ip_reg   <= cfg_data;
                ipv4rc_pkg::REG_LOCAL_PORT:  local_port_reg  <= cfg_data[15:0];
                ipv4rc_pkg::REG_REMOTE_PORT: remote_port_reg <= cfg_data[15:0];
                ipv4rc_pkg::REG_ECHO_ID:     echo_id_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign snap_take = !out_valid_reg || m_tready;

    ipv4rc_capture #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .mode       (mode_reg),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    assign src_match = snap.sender_ip == target_ip_reg;

    always_comb
    begin
        verdict_next = ipv4rc_pkg::VERDICT_NONE;
        flags_next   = '0;
        code_next    = '0;
        sport_next   = '0;
        case (snap.mode)
            ipv4rc_pkg::MODE_TCP:
            begin
                if (snap.len_ge_20 && snap.len_ge_hl_20 &&
                    snap.protocol == ipv4rc_pkg::PROTO_TCP && src_match &&
                    snap.first_word == remote_port_reg &&
                    snap.second_word == local_port_reg)
                begin
                    verdict_next = ipv4rc_pkg::VERDICT_TCP_REPLY;
                    flags_next   = snap.tcp_flags;
                    sport_next   = snap.first_word;
                end
            end
            ipv4rc_pkg::MODE_ICMP:
            begin
                if (snap.len_ge_20 && snap.len_ge_hl_8 &&
                    snap.protocol == ipv4rc_pkg::PROTO_ICMP)
                begin
                    if (snap.msg_type == ipv4rc_pkg::ICMP_ECHO_REPLY && src_match &&
                        snap.second_word == echo_id_reg)
                    begin
                        verdict_next = ipv4rc_pkg::VERDICT_ECHO_REPLY;
                        code_next    = snap.msg_code;
                    end
                    else if (snap.msg_type == ipv4rc_pkg::ICMP_UNREACHABLE)
                    begin
                        verdict_next = ipv4rc_pkg::VERDICT_UNREACHABLE;
                        code_next    = snap.msg_code;
                    end
                end
            end
            ipv4rc_pkg::MODE_UDP:
            begin
                // Source address is not checked: the reply comes from any router
                if (snap.len_ge_hl_8 && snap.protocol == ipv4rc_pkg::PROTO_ICMP &&
                    snap.msg_type == ipv4rc_pkg::ICMP_UNREACHABLE &&
                    snap.msg_code == ipv4rc_pkg::ICMP_PORT_UNREACH &&
                    snap.len_ge_hl_32 && snap.len_ge_inner &&
                    snap.inner_dest_port == remote_port_reg)
                begin
                    verdict_next = ipv4rc_pkg::VERDICT_PORT_UNREACH;
                    code_next    = snap.msg_code;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_take)
            out_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (snap_take && snap_valid)
        begin
            verdict_reg   <= verdict_next;
            flags_reg     <= flags_next;
            code_reg      <= code_next;
            sender_ip_reg <= snap.sender_ip;
            sport_reg     <= sport_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, sport_reg, sender_ip_reg, code_reg, flags_reg, verdict_reg};

    a_last_to_snap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> snap_valid)
        else $error("last byte accepted without a packet snapshot");

    a_tcp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && verdict_reg != ipv4rc_pkg::VERDICT_TCP_REPLY |->
            flags_reg == 8'd0 && sport_reg == 16'd0)
        else $error("tcp fields set on a non-tcp verdict");

    a_code_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (verdict_reg == ipv4rc_pkg::VERDICT_NONE ||
                     verdict_reg == ipv4rc_pkg::VERDICT_TCP_REPLY) |->
            code_reg == 8'd0)
        else $error("icmp code set on a non-icmp verdict");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && out_valid_reg && !m_tready |-> !s_tready)
        else $error("request accepted with both stages full");

endmodule

/* verif/tb_ipv4_response_classifier.sv */
module tb_ipv4_response_classifier;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          RANDOM_ITEMS   = 420;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;

    // Packet shapes produced by the generator
    localparam int PKT_TCP     = 0;
    localparam int PKT_ECHO    = 1;
    localparam int PKT_UNREACH = 2;
    localparam int PKT_NOISE   = 3;

    // Which field a generated packet gets wrong
    localparam int SPOIL_NONE   = 0;
    localparam int SPOIL_SRC    = 1;
    localparam int SPOIL_FIRST  = 2;
    localparam int SPOIL_SECOND = 3;

    typedef struct packed {
        ipv4rc_pkg::verdict_t verdict;
        logic [7:0]  flags;
        logic [7:0]  code;
        logic [31:0] src;
        logic [15:0] sport;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // Register shadow
    logic [1:0]  cfg_mode;
    logic [31:0] cfg_target;
    logic [15:0] cfg_lport;
    logic [15:0] cfg_rport;
    logic [15:0] cfg_echo;

    // Per-packet capture state of the predictor
    int          rx_count;
    int          ip_hdr_len;
    int          emb_hdr_len;
    logic [7:0]  ip_proto;
    logic [31:0] ip_src;
    logic [15:0] l4_word0;
    logic [15:0] l4_word1;
    logic [7:0]  tcp_flags;
    logic [7:0]  rx_type;
    logic [7:0]  rx_code;
    logic [15:0] emb_dport;

    reply_t      pending_verdicts[$];
    logic [7:0]  pkt_bytes[$];
    int          errors;
    int          items_sent;
    int          idle_cycles;
    bit          no_idle;

    ipv4_response_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_capture();
        rx_count    = 0;
        ip_hdr_len  = 0;
        emb_hdr_len = 0;
        ip_proto    = '0;
        ip_src      = '0;
        l4_word0    = '0;
        l4_word1    = '0;
        tcp_flags   = '0;
        rx_type     = '0;
        rx_code     = '0;
        emb_dport   = '0;
    endfunction

    function automatic reply_t judge_packet();
        reply_t r;
        r = '0;
        r.verdict = ipv4rc_pkg::VERDICT_NONE;
        r.src = ip_src;
        case (cfg_mode)
            ipv4rc_pkg::MODE_TCP:
                if (rx_count >= 20 && rx_count >= ip_hdr_len + 20 &&
                    ip_proto == ipv4rc_pkg::PROTO_TCP &&
                    ip_src == cfg_target && l4_word0 == cfg_rport && l4_word1 == cfg_lport)
                begin
                    r.verdict = ipv4rc_pkg::VERDICT_TCP_REPLY;
                    r.flags = tcp_flags;
                    r.sport = l4_word0;
                end
            ipv4rc_pkg::MODE_ICMP:
                if (rx_count >= 20 && rx_count >= ip_hdr_len + 8 &&
                    ip_proto == ipv4rc_pkg::PROTO_ICMP)
                begin
                    if (rx_type == ipv4rc_pkg::ICMP_ECHO_REPLY && ip_src == cfg_target &&
                        l4_word1 == cfg_echo)
                    begin
                        r.verdict = ipv4rc_pkg::VERDICT_ECHO_REPLY;
                        r.code = rx_code;
                    end
                    else if (rx_type == ipv4rc_pkg::ICMP_UNREACHABLE)
                    begin
                        r.verdict = ipv4rc_pkg::VERDICT_UNREACHABLE;
                        r.code = rx_code;
                    end
                end
            ipv4rc_pkg::MODE_UDP:
                if (rx_count >= ip_hdr_len + 8 && ip_proto == ipv4rc_pkg::PROTO_ICMP &&
                    rx_type == ipv4rc_pkg::ICMP_UNREACHABLE &&
                    rx_code == ipv4rc_pkg::ICMP_PORT_UNREACH &&
                    rx_count >= ip_hdr_len + 32 &&
                    rx_count >= ip_hdr_len + 8 + emb_hdr_len + 4 && emb_dport == cfg_rport)
                begin
                    r.verdict = ipv4rc_pkg::VERDICT_PORT_UNREACH;
                    r.code = rx_code;
                end
            default: ;
        endcase
        return r;
    endfunction

    // Update the capture state with one accepted byte; a last byte yields a verdict
    function automatic void capture_byte(logic [7:0] b, logic last);
        int p;
        int word1_at;
        int emb_at;
        if (rx_count < ipv4rc_pkg::CAPTURE_BYTES_DEF)
        begin
            p = rx_count;
            if (p == 0)
                ip_hdr_len = int'(b[3:0]) * 4;
            if (p == 9)
                ip_proto = b;
            if (p >= 12 && p <= 15)
                ip_src[8 * (15 - p) +: 8] = b;
            if (p == ip_hdr_len)
            begin
                l4_word0[15:8] = b;
                rx_type = b;
            end
            if (p == ip_hdr_len + 1)
            begin
                l4_word0[7:0] = b;
                rx_code = b;
            end
            word1_at = (cfg_mode == ipv4rc_pkg::MODE_TCP) ? ip_hdr_len + 2 : ip_hdr_len + 4;
            if (p == word1_at)
                l4_word1[15:8] = b;
            if (p == word1_at + 1)
                l4_word1[7:0] = b;
            if (p == ip_hdr_len + 13)
                tcp_flags = b;
            if (p == ip_hdr_len + 8)
                emb_hdr_len = int'(b[3:0]) * 4;
            emb_at = ip_hdr_len + 8 + emb_hdr_len;
            if (p == emb_at + 2)
                emb_dport[15:8] = b;
            if (p == emb_at + 3)
                emb_dport[7:0] = b;
            rx_count++;
        end
        if (last)
        begin
            pending_verdicts.push_back(judge_packet());
            clear_capture();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        capture_byte(b, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Hold the sender until every outstanding verdict has been checked
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            ipv4rc_pkg::REG_MODE:        cfg_mode   = val[1:0];
            ipv4rc_pkg::REG_TARGET_IP:   cfg_target = val;
            ipv4rc_pkg::REG_LOCAL_PORT:  cfg_lport  = val[15:0];
            ipv4rc_pkg::REG_REMOTE_PORT: cfg_rport  = val[15:0];
            ipv4rc_pkg::REG_ECHO_ID:     cfg_echo   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] m, input logic [31:0] tgt,
                             input logic [15:0] lport, input logic [15:0] rport,
                             input logic [15:0] eid);
        logic [31:0] junk;
        junk = $urandom;
        drain();
        // upper bits carry junk on all but the target address: only the low bits of those registers count
        write_reg(ipv4rc_pkg::REG_MODE, {junk[31:2], m});
        write_reg(ipv4rc_pkg::REG_TARGET_IP, tgt);
        write_reg(ipv4rc_pkg::REG_LOCAL_PORT, {junk[15:0], lport});
        write_reg(ipv4rc_pkg::REG_REMOTE_PORT, {junk[23:8], rport});
        write_reg(ipv4rc_pkg::REG_ECHO_ID, {junk[31:16], eid});
    endtask

    function automatic void put16(int off, logic [15:0] v);
        if (off + 1 < pkt_bytes.size())
        begin
            pkt_bytes[off]     = v[15:8];
            pkt_bytes[off + 1] = v[7:0];
        end
    endfunction

    function automatic logic [15:0] spoil16(logic [15:0] v, bit wrong);
        return wrong ? v ^ 16'($urandom_range(1, 65535)) : v;
    endfunction

    // Build one packet against the current register shadow
    function automatic void build_packet(int shape, int ihl, int spoil, int tail);
        int          hl;
        int          len;
        int          emb_ihl;
        int          emb_at;
        logic [31:0] src;
        hl = ihl * 4;
        emb_ihl = $urandom_range(5, 7);
        emb_at = hl + 8 + emb_ihl * 4;
        case (shape)
            PKT_TCP:     len = hl + 20 + tail;
            PKT_ECHO:    len = (hl + 8 + tail < 20) ? 20 : hl + 8 + tail;
            PKT_UNREACH: len = (emb_at + 4 + tail < hl + 32) ? hl + 32 : emb_at + 4 + tail;
            default:     len = 1 + tail;
        endcase
        pkt_bytes.delete();
        for (int i = 0; i < len; i++)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        if (shape == PKT_NOISE)
            return;
        src = (spoil == SPOIL_SRC) ? cfg_target ^ ($urandom | 32'd1) : cfg_target;
        pkt_bytes[0] = {4'h4, 4'(ihl)};
        pkt_bytes[9] = (shape == PKT_TCP) ? ipv4rc_pkg::PROTO_TCP : ipv4rc_pkg::PROTO_ICMP;
        for (int k = 0; k < 4; k++)
            pkt_bytes[12 + k] = src[31 - 8 * k -: 8];
        case (shape)
            PKT_TCP:
            begin
                put16(hl, spoil16(cfg_rport, spoil == SPOIL_FIRST));
                put16(hl + 2, spoil16(cfg_lport, spoil == SPOIL_SECOND));
            end
            PKT_ECHO:
            begin
                pkt_bytes[hl] = (spoil == SPOIL_FIRST) ? 8'($urandom_range(4, 255))
                                                        : ipv4rc_pkg::ICMP_ECHO_REPLY;
                if ($urandom_range(0, 1) == 0)
                    pkt_bytes[hl + 1] = 8'd0;
                put16(hl + 4, spoil16(cfg_echo, spoil == SPOIL_SECOND));
            end
            default:
            begin
                pkt_bytes[hl] = ipv4rc_pkg::ICMP_UNREACHABLE;
                pkt_bytes[hl + 1] = (spoil == SPOIL_SECOND) ? 8'($urandom_range(0, 255))
                                                             : ipv4rc_pkg::ICMP_PORT_UNREACH;
                pkt_bytes[hl + 8] = {4'h4, 4'(emb_ihl)};
                put16(emb_at + 2, spoil16(cfg_rport, spoil == SPOIL_FIRST));
            end
        endcase
    endfunction

    task automatic test_tcp_reply();
        configure(ipv4rc_pkg::MODE_TCP, 32'hC0A8_0A21, 16'hC350, 16'h0050, 16'h0000);
        build_packet(PKT_TCP, 5, SPOIL_NONE, 0);
        send_packet();
        build_packet(PKT_TCP, 5, SPOIL_SRC, 0);
        send_packet();
        build_packet(PKT_TCP, 6, SPOIL_SECOND, 2);
        send_packet();
    endtask

    task automatic test_icmp_reply();
        configure(ipv4rc_pkg::MODE_ICMP, 32'h0A00_0001, 16'h1234, 16'h0035, 16'hBEEF);
        build_packet(PKT_ECHO, 5, SPOIL_NONE, 0);
        send_packet();
        build_packet(PKT_ECHO, 5, SPOIL_SECOND, 0);
        send_packet();
        build_packet(PKT_UNREACH, 5, SPOIL_SRC, 0);
        send_packet();
    endtask

    task automatic test_udp_unreach();
        configure(ipv4rc_pkg::MODE_UDP, 32'h0A00_0002, 16'h4000, 16'h0208, 16'h0001);
        build_packet(PKT_UNREACH, 5, SPOIL_SRC, 0);
        send_packet();
        build_packet(PKT_UNREACH, 5, SPOIL_FIRST, 0);
        send_packet();
    endtask

    task automatic test_corner_cases();
        configure(ipv4rc_pkg::MODE_TCP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // one lone byte marked last
        build_packet(PKT_NOISE, 5, SPOIL_NONE, 0);
        send_packet();
        // matching header, then bytes well past the capture window
        build_packet(PKT_TCP, 5, SPOIL_NONE, 0);
        while (pkt_bytes.size() < ipv4rc_pkg::CAPTURE_BYTES_DEF + 40)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        send_packet();
        // zero header length: transport offsets land on the IP header
        build_packet(PKT_TCP, 0, SPOIL_NONE, 0);
        send_packet();
        build_packet(PKT_ECHO, 1, SPOIL_NONE, 0);
        send_packet();
        configure(MODE_SPARE, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
        build_packet(PKT_TCP, 5, SPOIL_NONE, 0);
        send_packet();
    endtask

    task automatic test_random_traffic();
        int          goal;
        int          phase;
        int          left;
        int          shape;
        int          ihl;
        int          spoil;
        int          roll;
        int          cut;
        logic [1:0]  m;
        logic [31:0] tgt;
        logic [15:0] lport;
        logic [15:0] rport;
        logic [15:0] eid;
        goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        left = 0;
        while (items_sent < goal)
        begin
            if (left == 0)
            begin
                m = (phase % 7 == 6) ? MODE_SPARE : 2'(phase % 3);
                if (phase == 0)
                    {tgt, lport, rport, eid} = '0;
                else if (phase == 1)
                    {tgt, lport, rport, eid} = '1;
                else
                    {tgt, lport, rport, eid} = 80'({$urandom, $urandom, $urandom});
                configure(m, tgt, lport, rport, eid);
                no_idle = (phase % 4 == 3);
                phase++;
                left = $urandom_range(4, 8);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10)
                shape = PKT_NOISE;
            else if (roll < 30)
                shape = $urandom_range(PKT_TCP, PKT_UNREACH);
            else if (cfg_mode == ipv4rc_pkg::MODE_TCP)
                shape = PKT_TCP;
            else if (cfg_mode == ipv4rc_pkg::MODE_ICMP)
                shape = $urandom_range(PKT_ECHO, PKT_UNREACH);
            else
                shape = PKT_UNREACH;
            ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
            spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(SPOIL_SRC, SPOIL_SECOND)
                                                 : SPOIL_NONE;
            build_packet(shape, ihl, spoil,
                         (shape == PKT_NOISE) ? $urandom_range(0, 40) : $urandom_range(0, 8));
            roll = $urandom_range(0, 99);
            if (roll < 10 && pkt_bytes.size() > 1)
            begin
                // cut the packet short
                cut = $urandom_range(1, pkt_bytes.size() - 1);
                while (pkt_bytes.size() > cut)
                    void'(pkt_bytes.pop_back());
            end
            else if (roll < 13)
            begin
                cut = $urandom_range(ipv4rc_pkg::CAPTURE_BYTES_DEF + 1,
                                     ipv4rc_pkg::CAPTURE_BYTES_DEF + 40);
                while (pkt_bytes.size() < cut)
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_packet();
            left--;
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall per request, field-by-field compare
    initial
    begin
        int     hold;
        reply_t want;
        reply_t got;
        m_tready = 1'b0;
        hold = 3;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.verdict = ipv4rc_pkg::verdict_t'(m_tdata[2:0]);
                got.flags   = m_tdata[10:3];
                got.code    = m_tdata[18:11];
                got.src     = m_tdata[50:19];
                got.sport   = m_tdata[66:51];
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected result: verdict %0d", got.verdict);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.verdict !== want.verdict)
                    begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
                        errors++;
                    end
                    if (got.flags !== want.flags)
                    begin
                        $error("reply_flags: expected %h, actual %h", want.flags, got.flags);
                        errors++;
                    end
                    if (got.code !== want.code)
                    begin
                        $error("icmp_code_out: expected %h, actual %h", want.code, got.code);
                        errors++;
                    end
                    if (got.src !== want.src)
                    begin
                        $error("sender_ip: expected %h, actual %h", want.src, got.src);
                        errors++;
                    end
                    if (got.sport !== want.sport)
                    begin
                        $error("source_port_out: expected %h, actual %h", want.sport, got.sport);
                        errors++;
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, 14);
            end
            else if (hold > 0)
                hold--;
            m_tready <= (hold == 0);
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = ipv4rc_pkg::REG_MODE;
        cfg_data   = '0;
        cfg_mode   = ipv4rc_pkg::MODE_TCP;
        cfg_target = '0;
        cfg_lport  = '0;
        cfg_rport  = '0;
        cfg_echo   = '0;
        errors     = 0;
        items_sent = 0;
        no_idle    = 1'b0;
        clear_capture();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tcp_reply();
        test_icmp_reply();
        test_udp_unreach();
        test_corner_cases();
        test_random_traffic();
        drain();
        // allow a margin before the final report
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
